// ===== src/crtc_pkg.sv =====
// shared types and constants for the clock replacement tag cache
package crtc_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 64;

	localparam int KEY_W       = 64;
	localparam int SLOT_W      = 4;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 8;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_INS  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

// ===== src/clock_replacement_tag_cache.sv =====
// fully associative tag directory with clock (second-chance) replacement
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       tdata: key; tuser: op
// m_*      out  m_tvalid / m_tready       tdata: slot; tuser: hit
//
// one request at a time; the tag store is a one-port-write, one-port-read ram
// lookup: one tag read per cycle through the tag ram
// insert: one used bit per cycle under the clock hand
// reset clears valid bits, used bits and the hand at once; tags need no clearing
// a result waiting on m_tready does not stop the next request being taken
module clock_replacement_tag_cache #(
	parameter int NUM_ENTRIES = crtc_pkg::NUM_ENTRIES_DEF,
	parameter int KEY_BITS    = crtc_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [crtc_pkg::IN_TDATA_W-1:0]    s_tdata,   // key[63:0]
	input  logic [0:0]                         s_tuser,   // op
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [crtc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // slot[3:0], zero[7:4]
	output logic [0:0]                         m_tuser    // hit
);

	localparam int IDX_W      = $clog2(NUM_ENTRIES);
	localparam int SLOT_EXT_W = (IDX_W > crtc_pkg::SLOT_W) ? IDX_W : crtc_pkg::SLOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

	crtc_pkg::state_t st_q;

	logic [KEY_BITS-1:0]    tag_mem [NUM_ENTRIES];
	logic [KEY_BITS-1:0]    rdata_s1;
	logic                   mem_we;

	logic [NUM_ENTRIES-1:0] valid_q;
	logic [NUM_ENTRIES-1:0] used_q;
	logic [IDX_W-1:0]       hand_q;
	logic [IDX_W-1:0]       hand_next;
	logic [KEY_BITS-1:0]    key_q;

	logic [IDX_W-1:0]       rd_addr_q;
	logic                   issue_q;
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic                   lk_hit;
	logic                   lk_miss;

	logic                   res_hit_q;
	logic [crtc_pkg::SLOT_W-1:0] res_slot_q;
	logic                   m_tvalid_q;
	logic                   m_hit_q;
	logic [crtc_pkg::SLOT_W-1:0] m_slot_q;
	logic                   out_free;
	logic                   s_acc;

	logic [SLOT_EXT_W-1:0]  hit_slot_ext;
	logic [SLOT_EXT_W-1:0]  hand_slot_ext;

	assign s_tready  = (st_q == crtc_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign hand_next = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
	assign mem_we    = (st_q == crtc_pkg::ST_INS) && !used_q[hand_q];

	assign lk_hit  = (st_q == crtc_pkg::ST_LOOK) && cmp_vld_s1 &&
			valid_q[cmp_idx_s1] && (rdata_s1 == key_q);
	assign lk_miss = (st_q == crtc_pkg::ST_LOOK) && cmp_vld_s1 && !lk_hit &&
			(cmp_idx_s1 == LAST_IDX);

	assign hit_slot_ext  = SLOT_EXT_W'(cmp_idx_s1);
	assign hand_slot_ext = SLOT_EXT_W'(hand_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(crtc_pkg::OUT_TDATA_W - crtc_pkg::SLOT_W){1'b0}}, m_slot_q};
	assign m_tuser  = m_hit_q;

	// tag ram
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[hand_q] <= key_q;
		end
		rdata_s1 <= tag_mem[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr_q;
		if (s_acc) begin
			key_q <= s_tdata[KEY_BITS-1:0];
		end
		if (lk_hit) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= hit_slot_ext[crtc_pkg::SLOT_W-1:0];
		end else if (lk_miss) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= '0;
		end else if (mem_we) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= hand_slot_ext[crtc_pkg::SLOT_W-1:0];
		end
		if (st_q == crtc_pkg::ST_DONE && out_free) begin
			m_hit_q  <= res_hit_q;
			m_slot_q <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= crtc_pkg::ST_IDLE;
			valid_q    <= '0;
			used_q     <= '0;
			hand_q     <= '0;
			rd_addr_q  <= '0;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (st_q == crtc_pkg::ST_LOOK) && issue_q;
			if (st_q == crtc_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				crtc_pkg::ST_IDLE: begin
					if (s_acc) begin
						rd_addr_q <= '0;
						issue_q   <= 1'b1;
						if (s_tuser[0] == crtc_pkg::OP_INSERT) begin
							st_q <= crtc_pkg::ST_INS;
						end else begin
							st_q <= crtc_pkg::ST_LOOK;
						end
					end
				end
				crtc_pkg::ST_LOOK: begin
					if (issue_q) begin
						if (rd_addr_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
						end
					end
					if (lk_hit) begin
						used_q[cmp_idx_s1] <= 1'b1;
						st_q <= crtc_pkg::ST_DONE;
					end else if (lk_miss) begin
						st_q <= crtc_pkg::ST_DONE;
					end
				end
				crtc_pkg::ST_INS: begin
					// second chance: clear and move on, else take this entry
					if (used_q[hand_q]) begin
						used_q[hand_q] <= 1'b0;
					end else begin
						valid_q[hand_q] <= 1'b1;
						used_q[hand_q]  <= 1'b1;
						st_q <= crtc_pkg::ST_DONE;
					end
					hand_q <= hand_next;
				end
				crtc_pkg::ST_DONE: begin
					if (out_free) begin
						st_q <= crtc_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= crtc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_insert_marks: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(hand_q)] && used_q[$past(hand_q)] && !res_hit_q)
		else $error("insert did not mark its entry valid and used");

	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= LAST_IDX)
		else $error("clock hand out of range");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == crtc_pkg::ST_DONE && out_free) |=>
			m_tvalid && (st_q == crtc_pkg::ST_IDLE))
		else $error("finished result not presented");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		lk_hit |=> res_hit_q && used_q[$past(cmp_idx_s1)])
		else $error("lookup hit not recorded");

endmodule
